@@ design/btx_pkg.sv @@
// Shared types, constants and helpers for the bilinear texture sampler.
// Depends on nothing; btx_texel_banks, btx_result_fifo and the top level import it.
package btx_pkg;

   // Default texture extents and the texel index width
   localparam int BTX_MAX_WIDTH  = 256;
   localparam int BTX_MAX_HEIGHT = 256;
   localparam int BTX_IDX_W      = 12;

   // Result queue depth (outstanding sample requests)
   localparam int BTX_RESULT_DEPTH = 16;

   // Register port
   localparam int BTX_CSR_IDX_W  = 3;
   localparam int BTX_CSR_DATA_W = 48;

   localparam logic [BTX_CSR_IDX_W-1:0] CSR_TEX_WIDTH      = 3'd0;
   localparam logic [BTX_CSR_IDX_W-1:0] CSR_TEX_HEIGHT     = 3'd1;
   localparam logic [BTX_CSR_IDX_W-1:0] CSR_DIFFUSE_COEFF  = 3'd2;
   localparam logic [BTX_CSR_IDX_W-1:0] CSR_SPECULAR_COEFF = 3'd3;
   localparam logic [BTX_CSR_IDX_W-1:0] CSR_REFLECT_COEFF  = 3'd4;

   // Request opcodes
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   typedef logic [23:0] btx_texel_type;

   // Texel write into the banked store
   typedef struct packed {
      logic          en;
      logic [7:0]    row;
      logic [7:0]    col;
      btx_texel_type rgb;
   } btx_wr_req_type;

   // The two columns and two rows of one 2x2 footprint
   typedef struct packed {
      logic [BTX_IDX_W-1:0] col0;
      logic [BTX_IDX_W-1:0] col1;
      logic [BTX_IDX_W-1:0] row0;
      logic [BTX_IDX_W-1:0] row1;
   } btx_rd_req_type;

   // Footprint texels: cXY, X = column step, Y = row step
   typedef struct packed {
      btx_texel_type c00;
      btx_texel_type c10;
      btx_texel_type c01;
      btx_texel_type c11;
   } btx_quad_type;

   typedef struct packed {
      logic [15:0] diffuse_r;
      logic [15:0] diffuse_g;
      logic [15:0] diffuse_b;
      logic [15:0] specular_r;
      logic [15:0] specular_g;
      logic [15:0] specular_b;
      logic [15:0] reflect_r;
      logic [15:0] reflect_g;
      logic [15:0] reflect_b;
   } btx_result_type;

   // Last usable texel index for an extent register, extent clamped to 2..max_ext
   function automatic logic [BTX_IDX_W-1:0] btx_extent_last(input logic [8:0] ext,
                                                           input int max_ext);
      logic [BTX_IDX_W-1:0] last;
      if (ext < 9'd2) begin
         last = BTX_IDX_W'(1);
      end else if (int'(ext) > max_ext) begin
         last = BTX_IDX_W'(max_ext - 1);
      end else begin
         last = BTX_IDX_W'(ext - 9'd1);
      end
      return last;
   endfunction

endpackage

@@ design/btx_interfaces.sv @@
// Request and response channel interfaces of the bilinear texture sampler.
// Valid/ready handshake; no package dependency.
interface btx_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [15:0] texel_addr;
   logic [23:0] texel_rgb;
   logic [15:0] u_coord;
   logic [15:0] v_coord;

   modport source(output valid, opcode, texel_addr, texel_rgb, u_coord, v_coord,
                  input ready);
   modport sink(input valid, opcode, texel_addr, texel_rgb, u_coord, v_coord,
                output ready);
endinterface

interface btx_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] diffuse_r;
   logic [15:0] diffuse_g;
   logic [15:0] diffuse_b;
   logic [15:0] specular_r;
   logic [15:0] specular_g;
   logic [15:0] specular_b;
   logic [15:0] reflect_r;
   logic [15:0] reflect_g;
   logic [15:0] reflect_b;

   modport source(output valid, diffuse_r, diffuse_g, diffuse_b, specular_r, specular_g,
                  specular_b, reflect_r, reflect_g, reflect_b,
                  input ready);
   modport sink(input valid, diffuse_r, diffuse_g, diffuse_b, specular_r, specular_g,
                specular_b, reflect_r, reflect_g, reflect_b,
                output ready);
endinterface

@@ design/btx_texel_banks.sv @@
// Texel store split into four banks by column and row parity, so all four
// texels of a 2x2 footprint are read together. Depends on btx_pkg.
module btx_texel_banks
   import btx_pkg::*;
#(
   parameter int MAX_WIDTH  = BTX_MAX_WIDTH,
   parameter int MAX_HEIGHT = BTX_MAX_HEIGHT
) (
   input  logic           clock,
   input  btx_wr_req_type wr_req,
   input  btx_rd_req_type rd_req,
   output btx_quad_type   texels
);

   localparam int HALF_W     = (MAX_WIDTH + 1) / 2;
   localparam int HALF_H     = (MAX_HEIGHT + 1) / 2;
   localparam int BANK_DEPTH = HALF_W * HALF_H;
   localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

   btx_texel_type rdata [4];
   // footprint parities: {row1, row0, col1, col0}
   logic [3:0]    par_ff;

   // Bank index is {row parity, column parity}
   for (genvar b = 0; b < 4; b++) begin : g_bank
      localparam logic BX = 1'(b % 2);
      localparam logic BY = 1'(b / 2);

      btx_texel_type        mem [BANK_DEPTH];
      btx_texel_type        q_ff;
      logic [BTX_IDX_W-1:0] rd_col;
      logic [BTX_IDX_W-1:0] rd_row;
      logic [BANK_AW-1:0]   rd_addr;
      logic [BANK_AW-1:0]   wr_addr;
      logic                 wr_hit;

      // Pick whichever footprint column/row falls in this bank
      always_comb begin
         rd_col  = (rd_req.col0[0] == BX) ? rd_req.col0 : rd_req.col1;
         rd_row  = (rd_req.row0[0] == BY) ? rd_req.row0 : rd_req.row1;
         rd_addr = BANK_AW'((rd_row >> 1) * HALF_W + (rd_col >> 1));
         wr_addr = BANK_AW'((wr_req.row >> 1) * HALF_W + (wr_req.col >> 1));
         wr_hit  = wr_req.en && (wr_req.col[0] == BX) && (wr_req.row[0] == BY);
      end

      always_ff @(posedge clock) begin
         if (wr_hit) begin
            mem[wr_addr] <= wr_req.rgb;
         end
         q_ff <= mem[rd_addr];
      end

      assign rdata[b] = q_ff;
   end

   always_ff @(posedge clock) begin
      par_ff <= {rd_req.row1[0], rd_req.row0[0], rd_req.col1[0], rd_req.col0[0]};
   end

   // Route bank outputs back to footprint positions
   always_comb begin
      texels.c00 = rdata[{par_ff[2], par_ff[0]}];
      texels.c10 = rdata[{par_ff[2], par_ff[1]}];
      texels.c01 = rdata[{par_ff[3], par_ff[0]}];
      texels.c11 = rdata[{par_ff[3], par_ff[1]}];
   end

endmodule

@@ design/btx_result_fifo.sv @@
// Result queue between the sampling pipeline and the response channel.
// Register-based circular buffer; depends on btx_pkg.
module btx_result_fifo
   import btx_pkg::*;
#(
   parameter int DEPTH = BTX_RESULT_DEPTH
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  btx_result_type push_data,
   input  logic           pop,
   output btx_result_type head,
   output logic           not_empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   btx_result_type   slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head      = slot_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);

endmodule

@@ design/bilinear_texture_sampler.sv @@
// Bilinear texture sampler top level: coordinate split, banked texel fetch,
// blend and coefficient scaling. Depends on btx_pkg, the channel interfaces,
// btx_texel_banks and btx_result_fifo.
//
// Usage:
//   req_chan carries write requests (opcode write: texel_addr, texel_rgb) and
//   sample requests (opcode sample: u_coord, v_coord). A write produces no
//   response; a sample produces one response on rsp_chan with the diffuse,
//   specular and reflection scaled colours.
//   Registers are written through csr_wr_en/csr_index/csr_wdata while no
//   request is outstanding.
//   Throughput: one request per cycle while req_chan.ready is high, reads and
//   writes mixed freely; the four parity banks of the texel store deliver a
//   whole 2x2 footprint each cycle. An accepted sample runs through a
//   seven-stage pipeline ending in the result queue, then shows on rsp_chan.
//   A write is visible to any sample accepted after it.
//   Stall: results collect in a 16-entry queue; req_chan.ready drops only when
//   16 samples are accepted and not yet taken, so a stalled receiver backs up
//   the request side and nothing is lost.
//   Reset clears the pipeline, the queue and the registers (extents 256,
//   coefficients 0). The texel store is not cleared; a texel reads undefined
//   until written.
module bilinear_texture_sampler
   import btx_pkg::*;
#(
   parameter int MAX_WIDTH  = BTX_MAX_WIDTH,
   parameter int MAX_HEIGHT = BTX_MAX_HEIGHT
) (
   input  logic                      clock,
   input  logic                      reset,
   btx_req_if.sink                   req_chan,
   btx_rsp_if.source                 rsp_chan,
   input  logic                      csr_wr_en,
   input  logic [BTX_CSR_IDX_W-1:0]  csr_index,
   input  logic [BTX_CSR_DATA_W-1:0] csr_wdata
);

   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int YW    = $clog2(MAX_HEIGHT);
   localparam int PXW   = XW + 16;
   localparam int PYW   = YW + 16;
   localparam int SPW   = BTX_IDX_W + 16;
   localparam int CNT_W = $clog2(BTX_RESULT_DEPTH + 1);

   // ---------------------------------------------------------------- registers
   logic [XW-1:0] w_last_ff;
   logic [YW-1:0] h_last_ff;
   logic [47:0]   diffuse_ff;
   logic [47:0]   specular_ff;
   logic [47:0]   reflect_ff;
   logic [47:0]   coeff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         w_last_ff   <= XW'(btx_extent_last(9'd256, MAX_WIDTH));
         h_last_ff   <= YW'(btx_extent_last(9'd256, MAX_HEIGHT));
         diffuse_ff  <= '0;
         specular_ff <= '0;
         reflect_ff  <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TEX_WIDTH:      w_last_ff   <= XW'(btx_extent_last(csr_wdata[8:0], MAX_WIDTH));
            CSR_TEX_HEIGHT:     h_last_ff   <= YW'(btx_extent_last(csr_wdata[8:0], MAX_HEIGHT));
            CSR_DIFFUSE_COEFF:  diffuse_ff  <= csr_wdata;
            CSR_SPECULAR_COEFF: specular_ff <= csr_wdata;
            CSR_REFLECT_COEFF:  reflect_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign coeff[0] = diffuse_ff;
   assign coeff[1] = specular_ff;
   assign coeff[2] = reflect_ff;

   // ------------------------------------------------------- request handshake
   logic             req_acc;
   logic             sample_acc;
   logic             rsp_pop;
   logic [CNT_W-1:0] credit_ff;
   logic [CNT_W-1:0] credit_in;

   assign req_chan.ready = (credit_ff < CNT_W'(BTX_RESULT_DEPTH));
   assign req_acc        = req_chan.valid && req_chan.ready;
   assign sample_acc     = req_acc && (req_chan.opcode == OP_SAMPLE);
   assign rsp_pop        = rsp_chan.valid && rsp_chan.ready;

   // Samples accepted and not yet taken; bounds the result queue
   assign credit_in = credit_ff + CNT_W'(sample_acc) - CNT_W'(rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
      end
   end

   // ------------------------------------- stage 1: scale coords by extent - 1
   logic           s1_vld_ff;
   logic           s1_wen_ff;
   logic           s1_wen_in;
   btx_wr_req_type s1_wr_ff;
   logic [PXW-1:0] s1_pu_ff;
   logic [PYW-1:0] s1_pv_ff;

   assign s1_wen_in = req_acc && (req_chan.opcode == OP_WRITE)
                      && (32'(req_chan.texel_addr[15:8]) < MAX_HEIGHT)
                      && (32'(req_chan.texel_addr[7:0]) < MAX_WIDTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s1_wen_ff <= 1'b0;
      end else begin
         s1_vld_ff <= sample_acc;
         s1_wen_ff <= s1_wen_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_wr_ff.en  <= 1'b1;
      s1_wr_ff.row <= req_chan.texel_addr[15:8];
      s1_wr_ff.col <= req_chan.texel_addr[7:0];
      s1_wr_ff.rgb <= req_chan.texel_rgb;
      s1_pu_ff     <= PXW'(w_last_ff) * PXW'(req_chan.u_coord);
      s1_pv_ff     <= PYW'(h_last_ff) * PYW'(req_chan.v_coord);
   end

   // ------------------------------- stage 2: divide by 65535, index/fraction
   // p = q0*65536 + lo = q0*65535 + (q0 + lo); one correction step suffices.
   // The Q0.16 fraction floor(rem*65536/65535) equals rem for rem < 65535.
   function automatic logic [SPW-1:0] split_coord(input logic [SPW-1:0] p);
      logic [BTX_IDX_W-1:0] q0;
      logic [16:0]          rem0;
      logic [SPW-1:0]       res;
      q0   = p[SPW-1:16];
      rem0 = {1'b0, p[15:0]} + 17'(q0);
      if (rem0 >= 17'd65535) begin
         res = {q0 + BTX_IDX_W'(1), 16'(rem0 - 17'd65535)};
      end else begin
         res = {q0, rem0[15:0]};
      end
      return res;
   endfunction

   logic           s2_vld_ff;
   logic           s2_wen_ff;
   btx_wr_req_type s2_wr_ff;
   logic [XW-1:0]  s2_i_ff;
   logic [XW-1:0]  s2_i1_ff;
   logic [YW-1:0]  s2_j_ff;
   logic [YW-1:0]  s2_j1_ff;
   logic [15:0]    s2_fu_ff;
   logic [15:0]    s2_fv_ff;
   logic [SPW-1:0] u_split;
   logic [SPW-1:0] v_split;
   logic [XW-1:0]  s2_i_in;
   logic [XW-1:0]  s2_i1_in;
   logic [YW-1:0]  s2_j_in;
   logic [YW-1:0]  s2_j1_in;

   always_comb begin
      u_split  = split_coord(SPW'(s1_pu_ff));
      v_split  = split_coord(SPW'(s1_pv_ff));
      s2_i_in  = XW'(u_split[SPW-1:16]);
      s2_j_in  = YW'(v_split[SPW-1:16]);
      // neighbour clamped at the last column/row in use
      s2_i1_in = (s2_i_in < w_last_ff) ? s2_i_in + XW'(1) : w_last_ff;
      s2_j1_in = (s2_j_in < h_last_ff) ? s2_j_in + YW'(1) : h_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
         s2_wen_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
         s2_wen_ff <= s1_wen_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_wr_ff <= s1_wr_ff;
      s2_i_ff  <= s2_i_in;
      s2_i1_ff <= s2_i1_in;
      s2_j_ff  <= s2_j_in;
      s2_j1_ff <= s2_j1_in;
      s2_fu_ff <= u_split[15:0];
      s2_fv_ff <= v_split[15:0];
   end

   // -------------------------------------------- stage 3: banked texel fetch
   btx_wr_req_type bank_wr;
   btx_rd_req_type bank_rd;
   btx_quad_type   quad;
   logic           s3_vld_ff;
   logic [15:0]    s3_fu_ff;
   logic [15:0]    s3_fv_ff;

   always_comb begin
      bank_wr      = s2_wr_ff;
      bank_wr.en   = s2_wen_ff;
      bank_rd.col0 = BTX_IDX_W'(s2_i_ff);
      bank_rd.col1 = BTX_IDX_W'(s2_i1_ff);
      bank_rd.row0 = BTX_IDX_W'(s2_j_ff);
      bank_rd.row1 = BTX_IDX_W'(s2_j1_ff);
   end

   btx_texel_banks #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_banks (
      .clock (clock),
      .wr_req(bank_wr),
      .rd_req(bank_rd),
      .texels(quad)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_fu_ff <= s2_fu_ff;
      s3_fv_ff <= s2_fv_ff;
   end

   // --------------------------------------- stage 4: blend along rows, Q8.16
   logic        s4_vld_ff;
   logic [15:0] s4_fv_ff;
   logic [23:0] s4_top_ff [3];
   logic [23:0] s4_bot_ff [3];
   logic [24:0] top_in [3];
   logic [24:0] bot_in [3];
   logic [16:0] wu0;

   always_comb begin
      wu0 = 17'h10000 - 17'(s3_fu_ff);
      for (int c = 0; c < 3; c++) begin
         top_in[c] = 25'(quad.c00[23-8*c -: 8]) * 25'(wu0)
                   + 25'(quad.c10[23-8*c -: 8]) * 25'(s3_fu_ff);
         bot_in[c] = 25'(quad.c01[23-8*c -: 8]) * 25'(wu0)
                   + 25'(quad.c11[23-8*c -: 8]) * 25'(s3_fu_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s4_fv_ff <= s3_fv_ff;
      for (int c = 0; c < 3; c++) begin
         s4_top_ff[c] <= top_in[c][23:0];
         s4_bot_ff[c] <= bot_in[c][23:0];
      end
   end

   // ------------------------------------- stage 5: blend along columns, Q8.32
   logic        s5_vld_ff;
   logic [39:0] s5_col_ff [3];
   logic [40:0] col_in [3];
   logic [16:0] wv0;

   always_comb begin
      wv0 = 17'h10000 - 17'(s4_fv_ff);
      for (int c = 0; c < 3; c++) begin
         col_in[c] = 41'(s4_top_ff[c]) * 41'(wv0) + 41'(s4_bot_ff[c]) * 41'(s4_fv_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else begin
         s5_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         s5_col_ff[c] <= col_in[c][39:0];
      end
   end

   // --------------------- stage 6: colour times coefficient, split in halves
   // index [k][c]: k = diffuse/specular/reflect, c = r/g/b
   logic        s6_vld_ff;
   logic [35:0] s6_ph_ff [3][3];
   logic [35:0] s6_pl_ff [3][3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_vld_ff <= 1'b0;
      end else begin
         s6_vld_ff <= s5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         for (int c = 0; c < 3; c++) begin
            s6_ph_ff[k][c] <= 36'(s5_col_ff[c][39:20]) * 36'(coeff[k][47-16*c -: 16]);
            s6_pl_ff[k][c] <= 36'(s5_col_ff[c][19:0]) * 36'(coeff[k][47-16*c -: 16]);
         end
      end
   end

   // ------------------------ stage 7: round Q9.47 to Q8.8, saturate, enqueue
   logic [56:0]    prod_sum [3][3];
   logic [17:0]    prod_q [3][3];
   logic [15:0]    res_val [3][3];
   btx_result_type result;
   btx_result_type head;
   logic           fifo_not_empty;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int c = 0; c < 3; c++) begin
            prod_sum[k][c] = (57'(s6_ph_ff[k][c]) << 20) + 57'(s6_pl_ff[k][c])
                           + (57'(1) << 38);
            prod_q[k][c]   = prod_sum[k][c][56:39];
            res_val[k][c]  = (prod_q[k][c] > 18'd65535) ? 16'hFFFF : prod_q[k][c][15:0];
         end
      end
      result.diffuse_r  = res_val[0][0];
      result.diffuse_g  = res_val[0][1];
      result.diffuse_b  = res_val[0][2];
      result.specular_r = res_val[1][0];
      result.specular_g = res_val[1][1];
      result.specular_b = res_val[1][2];
      result.reflect_r  = res_val[2][0];
      result.reflect_g  = res_val[2][1];
      result.reflect_b  = res_val[2][2];
   end

   btx_result_fifo #(
      .DEPTH(BTX_RESULT_DEPTH)
   ) u_results (
      .clock    (clock),
      .reset    (reset),
      .push     (s6_vld_ff),
      .push_data(result),
      .pop      (rsp_pop),
      .head     (head),
      .not_empty(fifo_not_empty)
   );

   // ---------------------------------------------------------- response side
   assign rsp_chan.valid      = fifo_not_empty;
   assign rsp_chan.diffuse_r  = head.diffuse_r;
   assign rsp_chan.diffuse_g  = head.diffuse_g;
   assign rsp_chan.diffuse_b  = head.diffuse_b;
   assign rsp_chan.specular_r = head.specular_r;
   assign rsp_chan.specular_g = head.specular_g;
   assign rsp_chan.specular_b = head.specular_b;
   assign rsp_chan.reflect_r  = head.reflect_r;
   assign rsp_chan.reflect_g  = head.reflect_g;
   assign rsp_chan.reflect_b  = head.reflect_b;

endmodule
